/* src/rca_pkg.sv */
// ----------------------------------------------------------------------------
// Rainbow chain AES-128 package
// Shared constants, the AES S-box and the password character table.
// ----------------------------------------------------------------------------
package rca_pkg;

  localparam int unsigned MaxPwdLen = 10;
  localparam int unsigned IdxW      = 60;
  localparam int unsigned LenW      = 4;
  localparam int unsigned ChainW    = 32;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [CfgIdxW-1:0] CfgPwdLen   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgChainLen = 1'b1;

  localparam logic [LenW-1:0] PwdLenReset   = 4'd4;
  localparam logic [ChainW-1:0] ChainLenReset = 32'd100;

  // Round control towards the round unit
  typedef struct packed {
    logic load;   // load state and key from the password block
    logic round;  // run one round
    logic last;   // final round: skip MixColumns
  } rca_ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  // Multiply by x in GF(2^8)
  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Map a base-64 digit to its character
  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] c;
    if (d < 6'd26)      c = 8'h61 + {2'b00, d};
    else if (d < 6'd52) c = 8'h41 + {2'b00, d} - 8'd26;
    else if (d < 6'd62) c = 8'h30 + {2'b00, d} - 8'd52;
    else if (d == 6'd62) c = 8'h3f;
    else                c = 8'h21;
    return c;
  endfunction

endpackage

/* src/rca_round.sv */
// ----------------------------------------------------------------------------
// Rainbow chain AES round unit
// Holds the AES state and round key; one round per cycle while round is set.
// ----------------------------------------------------------------------------
module rca_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rca_pkg::rca_ctrl_t ctrl_i,
  input  logic [127:0]      block_i,
  input  logic [7:0]        rcon_i,
  output logic [127:0]      state_o
);

  logic [127:0] state_q, state_d, key_q, key_d;
  logic [7:0]   s   [16];
  logic [7:0]   sb  [16];
  logic [7:0]   mc  [16];
  logic [7:0]   k   [16];
  logic [7:0]   nk  [16];

  // Byte i sits at bits [8*i+7:8*i]
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_q[8*i +: 8];
      k[i] = key_q[8*i +: 8];
    end
    // SubBytes and ShiftRows
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sb[c*4+i] = rca_pkg::sbox(s[((c + i) % 4)*4 + i]);
      end
    end
    // MixColumns
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        mc[c*4+i] = sb[c*4+i] ^ (sb[c*4] ^ sb[c*4+1] ^ sb[c*4+2] ^ sb[c*4+3]) ^
                    rca_pkg::xt(sb[c*4+i] ^ sb[c*4+((i+1)%4)]);
      end
    end
    // Key schedule step
    nk[0] = k[0] ^ rca_pkg::sbox(k[13]) ^ rcon_i;
    nk[1] = k[1] ^ rca_pkg::sbox(k[14]);
    nk[2] = k[2] ^ rca_pkg::sbox(k[15]);
    nk[3] = k[3] ^ rca_pkg::sbox(k[12]);
    for (int i = 4; i < 16; i++) begin
      nk[i] = k[i] ^ nk[i-4];
    end
    state_d = state_q;
    key_d   = key_q;
    if (ctrl_i.load) begin
      // Initial AddRoundKey of a block with itself gives zero
      state_d = '0;
      key_d   = block_i;
    end else if (ctrl_i.round) begin
      for (int i = 0; i < 16; i++) begin
        key_d[8*i +: 8]   = nk[i];
        state_d[8*i +: 8] = (ctrl_i.last ? sb[i] : mc[i]) ^ nk[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      key_q   <= '0;
    end else begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign state_o = state_q;

`ifndef SYNTH
  // A load clears the state
  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.load |=> state_q == '0) else $error("state not cleared on load");
  // Idle cycles keep the state
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.load && !ctrl_i.round |=> $stable(state_q)) else $error("state moved");
  // Load and round never coincide
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.load && ctrl_i.round)) else $error("load during round");
`endif

endmodule

/* src/rainbow_chain_aes128_core.sv */
// ----------------------------------------------------------------------------
// Rainbow chain AES-128 core
// Walks one rainbow chain per start index and returns the end index.
// ----------------------------------------------------------------------------
// Per item: the start index is taken in the idle state; an empty chain then
// goes straight to the output. Otherwise each link has a load state and the ten
// AES rounds through the single round unit, and a last pass through the load
// state closes the final link before the result is handed over. Each load state
// also closes the link before it. The block is not ready while a chain runs; the
// result waits in an output register, and an output stall holds it there.
module rainbow_chain_aes128_core #(
  parameter int unsigned MAX_PWD_LEN = rca_pkg::MaxPwdLen
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rca_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rca_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rca_pkg::IdxW-1:0]       start_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rca_pkg::IdxW-1:0]       end_index_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLoad = 2'd1;
  localparam logic [1:0] StRnd  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0]  st_q, st_d;
  logic [rca_pkg::LenW-1:0]   pwd_len_q, len_eff;
  logic [rca_pkg::ChainW-1:0] chain_len_q, step_q, step_d;
  logic [rca_pkg::IdxW-1:0]   cur_q, cur_d, mask;
  logic [rca_pkg::IdxW-1:0]   next_idx, link_idx;
  logic [3:0]  rnd_q, rnd_d;
  logic [7:0]  rcon_q, rcon_d;
  logic [127:0] block, state;
  logic [7:0]  pwd [MAX_PWD_LEN];
  logic [63:0] sum;
  logic        link_done_q;
  rca_pkg::rca_ctrl_t ctrl;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwd_len_q   <= rca_pkg::PwdLenReset;
      chain_len_q <= rca_pkg::ChainLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rca_pkg::CfgPwdLen:   pwd_len_q   <= cfg_data_i[rca_pkg::LenW-1:0];
        rca_pkg::CfgChainLen: chain_len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp length and build the index mask
  always_comb begin
    len_eff = pwd_len_q;
    if (len_eff == '0) len_eff = 4'd1;
    if (32'(len_eff) > MAX_PWD_LEN) len_eff = 4'(MAX_PWD_LEN);
    mask = '0;
    for (int d = 0; d < MAX_PWD_LEN; d++) begin
      if (d < int'(len_eff)) mask[6*d +: 6] = 6'h3f;
    end
  end

  // Close the link: add the link number to the ciphertext and reduce
  assign sum      = state[63:0] + {32'd0, step_q};
  assign next_idx = sum[rca_pkg::IdxW-1:0] & mask;
  assign link_idx = link_done_q ? next_idx : cur_q;

  // Spell the index and repeat the characters over the block
  always_comb begin
    int j;
    for (int x = 0; x < MAX_PWD_LEN; x++) begin
      pwd[x] = 8'h61;
      if (x < int'(len_eff)) begin
        pwd[x] = rca_pkg::digit_char(link_idx[6*(int'(len_eff)-1-x) +: 6]);
      end
    end
    block = '0;
    j = 0;
    for (int l = 1; l <= MAX_PWD_LEN; l++) begin
      if (int'(len_eff) == l) begin
        j = 0;
        for (int i = 0; i < 16; i++) begin
          block[8*i +: 8] = pwd[j];
          j = (j == l - 1) ? 0 : j + 1;
        end
      end
    end
  end

  rca_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .block_i(block),
    .rcon_i (rcon_q),
    .state_o(state)
  );

  // Chain sequencer
  always_comb begin
    st_d   = st_q;
    cur_d  = cur_q;
    step_d = step_q;
    rnd_d  = rnd_q;
    rcon_d = rcon_q;
    ctrl   = '0;
    case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          cur_d  = start_index_i & mask;
          step_d = '0;
          st_d   = (chain_len_q == '0) ? StOut : StLoad;
        end
      end
      StLoad: begin
        // Advance the index past the link that just finished
        if (link_done_q) begin
          cur_d  = next_idx;
          step_d = step_q + 32'd1;
        end
        if (link_done_q && (step_q + 32'd1 == chain_len_q)) begin
          st_d = StOut;
        end else begin
          ctrl.load = 1'b1;
          rnd_d  = 4'd1;
          rcon_d = 8'h01;
          st_d   = StRnd;
        end
      end
      StRnd: begin
        ctrl.round = 1'b1;
        ctrl.last  = (rnd_q == 4'd10);
        rnd_d  = rnd_q + 4'd1;
        rcon_d = rca_pkg::xt(rcon_q);
        if (rnd_q == 4'd10) begin
          st_d = StLoad;
        end
      end
      StOut: begin
        if (out_ready_i) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  // Flag the cycle after the final round of a link
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      step_q      <= '0;
      rnd_q       <= '0;
      rcon_q      <= '0;
      link_done_q <= 1'b0;
      cur_q       <= '0;
    end else begin
      link_done_q <= (st_q == StRnd) && (rnd_q == 4'd10);
      st_q        <= st_d;
      step_q      <= step_d;
      rnd_q       <= rnd_d;
      rcon_q      <= rcon_d;
      cur_q       <= cur_d;
    end
  end

  assign in_ready_o  = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);
  assign end_index_o = cur_q;

`ifndef SYNTH
  // The result stays put while it waits
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(end_index_o))
    else $error("result changed while waiting");
  // Never ready and valid at once
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  // A link closes only after the final round
  a_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_done_q |-> $past(rnd_q) == 4'd10) else $error("link closed early");
`endif

endmodule
